// ----- rtl/core/bpnt_pkg.sv -----
`default_nettype none
package bpnt_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 32;
   localparam int IDX_WIDTH   = $clog2(TABLE_DEPTH);
   localparam int COUNT_WIDTH = $clog2(TABLE_DEPTH + 1);
   localparam logic [IDX_WIDTH-1:0] IDX_LAST = IDX_WIDTH'(TABLE_DEPTH - 1);

   // field widths
   localparam int ADDR_WIDTH   = 16;
   localparam int METRIC_WIDTH = 16;
   localparam int RSSI_WIDTH   = 8;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   // transaction kinds
   localparam logic KIND_BEACON = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IS_ROOT            = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOST_THRESHOLD     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNREACHABLE_METRIC = 2'd2;

   // reset values and saturation bounds
   localparam logic signed [METRIC_WIDTH-1:0] LOST_THRESHOLD_RESET     = -16'sd400;
   localparam logic signed [METRIC_WIDTH-1:0] UNREACHABLE_METRIC_RESET = -16'sd999;
   localparam logic signed [METRIC_WIDTH-1:0] METRIC_MAX = 16'sh7fff;
   localparam logic signed [METRIC_WIDTH-1:0] METRIC_MIN = -16'sh8000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_WRITE,
      ST_SELECT,
      ST_COMMIT,
      ST_RESPOND
   } state_type;

   // saturate the 17-bit sum of path metric and link RSSI
   function automatic logic signed [METRIC_WIDTH-1:0] sat_metric(
      input logic signed [METRIC_WIDTH:0] sum
   );
      logic signed [METRIC_WIDTH-1:0] res;
      if (sum[METRIC_WIDTH] == sum[METRIC_WIDTH-1]) begin
         res = sum[METRIC_WIDTH-1:0];
      end else if (sum[METRIC_WIDTH]) begin
         res = METRIC_MIN;
      end else begin
         res = METRIC_MAX;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/best_parent_neighbor_table.sv -----
`default_nettype none
// Channel  | Ports                                            | Handshake
// ---------+--------------------------------------------------+--------------------------------
// request  | req_kind, req_neighbor_addr, req_path_metric,    | taken when start & !busy
//          | req_link_rssi                                    |
// response | rsp_parent_addr, rsp_node_metric,                | rsp_strobe, one cycle, no stall
//          | rsp_parent_changed, rsp_send_allowed,            |
//          | rsp_insert_dropped, rsp_entry_count              |
// csr      | csr_write_enable, csr_index, csr_write_data      | written on any enabled edge
//
// A beacon makes one compare unit walk the table once to find a match or a free slot,
// and again to pick the best metric. An aging tick walks the table once to find the
// oldest entry; a beacon in root mode goes straight to the response. busy is high from the
// accepting edge until the response strobe has gone. Reset is synchronous and clears the
// valid bits, the entry count and the chosen parent; the response cannot be held off.
module best_parent_neighbor_table (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   output logic                                          busy,
   input  wire logic                                     req_kind,
   input  wire logic [bpnt_pkg::ADDR_WIDTH-1:0]          req_neighbor_addr,
   input  wire logic signed [bpnt_pkg::METRIC_WIDTH-1:0] req_path_metric,
   input  wire logic signed [bpnt_pkg::RSSI_WIDTH-1:0]   req_link_rssi,
   output logic                                          rsp_strobe,
   output logic [bpnt_pkg::ADDR_WIDTH-1:0]               rsp_parent_addr,
   output logic signed [bpnt_pkg::METRIC_WIDTH-1:0]      rsp_node_metric,
   output logic                                          rsp_parent_changed,
   output logic                                          rsp_send_allowed,
   output logic                                          rsp_insert_dropped,
   output logic [bpnt_pkg::COUNT_WIDTH-1:0]              rsp_entry_count,
   input  wire logic                                     csr_write_enable,
   input  wire logic [bpnt_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [bpnt_pkg::CSR_DATA_WIDTH-1:0]      csr_write_data
);

   // configuration
   logic                                          is_root_ff;
   logic signed [bpnt_pkg::METRIC_WIDTH-1:0]      lost_threshold_ff;
   logic signed [bpnt_pkg::METRIC_WIDTH-1:0]      unreachable_metric_ff;

   // neighbour table
   logic [bpnt_pkg::TABLE_DEPTH-1:0]              entry_valid_ff;
   logic [bpnt_pkg::ADDR_WIDTH-1:0]               entry_addr_ff   [bpnt_pkg::TABLE_DEPTH];
   logic signed [bpnt_pkg::METRIC_WIDTH-1:0]      entry_metric_ff [bpnt_pkg::TABLE_DEPTH];
   logic [bpnt_pkg::IDX_WIDTH-1:0]                entry_rank_ff   [bpnt_pkg::TABLE_DEPTH];
   logic [bpnt_pkg::COUNT_WIDTH-1:0]              count_ff, count_in;

   // chosen parent
   logic [bpnt_pkg::ADDR_WIDTH-1:0]               chosen_parent_ff, chosen_parent_in;
   logic signed [bpnt_pkg::METRIC_WIDTH-1:0]      chosen_metric_ff, chosen_metric_in;
   logic                                          parent_known_ff, parent_known_in;

   // sequencer
   bpnt_pkg::state_type                           state_ff, state_in;
   logic [bpnt_pkg::IDX_WIDTH-1:0]                idx_ff, idx_in;
   logic                                          kind_ff, kind_in;
   logic [bpnt_pkg::ADDR_WIDTH-1:0]               addr_ff, addr_in;
   logic signed [bpnt_pkg::METRIC_WIDTH-1:0]      metric_ff, metric_in;
   logic                                          found_ff, found_in;
   logic [bpnt_pkg::IDX_WIDTH-1:0]                found_idx_ff, found_idx_in;
   logic                                          free_ff, free_in;
   logic [bpnt_pkg::IDX_WIDTH-1:0]                free_idx_ff, free_idx_in;
   logic                                          have_ff, have_in;
   logic [bpnt_pkg::ADDR_WIDTH-1:0]               best_addr_ff, best_addr_in;
   logic signed [bpnt_pkg::METRIC_WIDTH-1:0]      best_metric_ff, best_metric_in;
   logic [bpnt_pkg::IDX_WIDTH-1:0]                best_rank_ff, best_rank_in;
   logic                                          changed_ff, changed_in;
   logic                                          dropped_ff, dropped_in;

   // table write strobes
   logic                                          upd_en, ins_en, clr_en;

   // entry under the compare unit
   logic                                          cur_valid;
   logic [bpnt_pkg::ADDR_WIDTH-1:0]               cur_addr;
   logic signed [bpnt_pkg::METRIC_WIDTH-1:0]      cur_metric;
   logic [bpnt_pkg::IDX_WIDTH-1:0]                cur_rank;
   logic [bpnt_pkg::IDX_WIDTH-1:0]                oldest_rank;
   logic                                          accept;
   logic signed [bpnt_pkg::METRIC_WIDTH:0]        req_sum;

   assign accept      = start && !busy;
   assign cur_valid   = entry_valid_ff[idx_ff];
   assign cur_addr    = entry_addr_ff[idx_ff];
   assign cur_metric  = entry_metric_ff[idx_ff];
   assign cur_rank    = entry_rank_ff[idx_ff];
   assign oldest_rank = bpnt_pkg::IDX_WIDTH'(count_ff - 1'b1);
   assign req_sum     = {req_path_metric[bpnt_pkg::METRIC_WIDTH-1], req_path_metric}
                        + {{(bpnt_pkg::METRIC_WIDTH - bpnt_pkg::RSSI_WIDTH + 1)
                             {req_link_rssi[bpnt_pkg::RSSI_WIDTH-1]}}, req_link_rssi};

   // next state and table strobes
   always_comb begin
      state_in         = state_ff;
      idx_in           = idx_ff;
      kind_in          = kind_ff;
      addr_in          = addr_ff;
      metric_in        = metric_ff;
      found_in         = found_ff;
      found_idx_in     = found_idx_ff;
      free_in          = free_ff;
      free_idx_in      = free_idx_ff;
      have_in          = have_ff;
      best_addr_in     = best_addr_ff;
      best_metric_in   = best_metric_ff;
      best_rank_in     = best_rank_ff;
      changed_in       = changed_ff;
      dropped_in       = dropped_ff;
      count_in         = count_ff;
      chosen_parent_in = chosen_parent_ff;
      chosen_metric_in = chosen_metric_ff;
      parent_known_in  = parent_known_ff;
      upd_en           = 1'b0;
      ins_en           = 1'b0;
      clr_en           = 1'b0;

      case (state_ff)
         bpnt_pkg::ST_IDLE: begin
            if (accept) begin
               kind_in    = req_kind;
               addr_in    = req_neighbor_addr;
               metric_in  = bpnt_pkg::sat_metric(req_sum);
               idx_in     = '0;
               found_in   = 1'b0;
               free_in    = 1'b0;
               have_in    = 1'b0;
               changed_in = 1'b0;
               dropped_in = 1'b0;
               // root ignores beacons outright
               if (req_kind == bpnt_pkg::KIND_BEACON && is_root_ff) begin
                  state_in = bpnt_pkg::ST_RESPOND;
               end else begin
                  state_in = bpnt_pkg::ST_MATCH;
               end
            end
         end
         bpnt_pkg::ST_MATCH: begin
            // look for the matching (or oldest) entry and the first free slot
            if (cur_valid && !found_ff) begin
               if ((kind_ff == bpnt_pkg::KIND_TICK && cur_rank == oldest_rank) ||
                   (kind_ff == bpnt_pkg::KIND_BEACON && cur_addr == addr_ff)) begin
                  found_in     = 1'b1;
                  found_idx_in = idx_ff;
               end
            end
            if (!cur_valid && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = idx_ff;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == bpnt_pkg::IDX_LAST) begin
               state_in = bpnt_pkg::ST_WRITE;
            end
         end
         bpnt_pkg::ST_WRITE: begin
            idx_in = '0;
            if (kind_ff == bpnt_pkg::KIND_TICK) begin
               // drop the oldest entry only when more than one is held
               if (count_ff > bpnt_pkg::COUNT_WIDTH'(1) && found_ff) begin
                  clr_en   = 1'b1;
                  count_in = count_ff - 1'b1;
               end
               state_in = bpnt_pkg::ST_RESPOND;
            end else begin
               if (found_ff) begin
                  upd_en = 1'b1;
               end else if (free_ff) begin
                  ins_en   = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  dropped_in = 1'b1;
               end
               state_in = bpnt_pkg::ST_SELECT;
            end
         end
         bpnt_pkg::ST_SELECT: begin
            // greatest metric wins, newest entry on a tie
            if (cur_valid && (!have_ff || cur_metric > best_metric_ff ||
                              (cur_metric == best_metric_ff && cur_rank < best_rank_ff))) begin
               have_in        = 1'b1;
               best_addr_in   = cur_addr;
               best_metric_in = cur_metric;
               best_rank_in   = cur_rank;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == bpnt_pkg::IDX_LAST) begin
               state_in = bpnt_pkg::ST_COMMIT;
            end
         end
         bpnt_pkg::ST_COMMIT: begin
            if (have_ff) begin
               changed_in       = !parent_known_ff || best_addr_ff != chosen_parent_ff;
               chosen_parent_in = best_addr_ff;
               chosen_metric_in = best_metric_ff;
               parent_known_in  = 1'b1;
            end
            state_in = bpnt_pkg::ST_RESPOND;
         end
         bpnt_pkg::ST_RESPOND: begin
            state_in = bpnt_pkg::ST_IDLE;
         end
         default: begin
            state_in = bpnt_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff              <= bpnt_pkg::ST_IDLE;
         entry_valid_ff        <= '0;
         count_ff              <= '0;
         chosen_parent_ff      <= '0;
         chosen_metric_ff      <= bpnt_pkg::UNREACHABLE_METRIC_RESET;
         parent_known_ff       <= 1'b0;
         is_root_ff            <= 1'b0;
         lost_threshold_ff     <= bpnt_pkg::LOST_THRESHOLD_RESET;
         unreachable_metric_ff <= bpnt_pkg::UNREACHABLE_METRIC_RESET;
      end else begin
         state_ff         <= state_in;
         count_ff         <= count_in;
         chosen_parent_ff <= chosen_parent_in;
         chosen_metric_ff <= chosen_metric_in;
         parent_known_ff  <= parent_known_in;
         if (ins_en) begin
            entry_valid_ff[free_idx_ff] <= 1'b1;
         end
         if (clr_en) begin
            entry_valid_ff[found_idx_ff] <= 1'b0;
         end
         // take configuration writes
         if (csr_write_enable) begin
            case (csr_index)
               bpnt_pkg::CSR_IS_ROOT:            is_root_ff <= csr_write_data[0];
               bpnt_pkg::CSR_LOST_THRESHOLD:     lost_threshold_ff <= csr_write_data;
               bpnt_pkg::CSR_UNREACHABLE_METRIC: unreachable_metric_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      kind_ff        <= kind_in;
      addr_ff        <= addr_in;
      metric_ff      <= metric_in;
      found_ff       <= found_in;
      found_idx_ff   <= found_idx_in;
      free_ff        <= free_in;
      free_idx_ff    <= free_idx_in;
      have_ff        <= have_in;
      best_addr_ff   <= best_addr_in;
      best_metric_ff <= best_metric_in;
      best_rank_ff   <= best_rank_in;
      changed_ff     <= changed_in;
      dropped_ff     <= dropped_in;
   end

   // table payload: age every held entry on insert, then write the new one
   always_ff @(posedge clock) begin
      if (ins_en) begin
         for (int i = 0; i < bpnt_pkg::TABLE_DEPTH; i++) begin
            if (entry_valid_ff[i]) begin
               entry_rank_ff[i] <= entry_rank_ff[i] + 1'b1;
            end
         end
         entry_addr_ff[free_idx_ff]   <= addr_ff;
         entry_metric_ff[free_idx_ff] <= metric_ff;
         entry_rank_ff[free_idx_ff]   <= '0;
      end
      if (upd_en) begin
         entry_metric_ff[found_idx_ff] <= metric_ff;
      end
   end

   // response
   always_comb begin
      if (is_root_ff) begin
         rsp_node_metric = '0;
      end else if (parent_known_ff) begin
         rsp_node_metric = chosen_metric_ff;
      end else begin
         rsp_node_metric = unreachable_metric_ff;
      end
   end

   assign busy               = state_ff != bpnt_pkg::ST_IDLE;
   assign rsp_strobe         = state_ff == bpnt_pkg::ST_RESPOND;
   assign rsp_parent_addr    = chosen_parent_ff;
   assign rsp_parent_changed = changed_ff;
   assign rsp_send_allowed   = rsp_node_metric > lost_threshold_ff;
   assign rsp_insert_dropped = dropped_ff;
   assign rsp_entry_count    = count_ff;

endmodule
`default_nettype wire
